>>> rtl/qru_pkg.sv
package qru_pkg;

   // default number format, signed q2.14
   localparam int WORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 14;

   // operation field
   localparam int OP_BITS = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_IDENTITY  = 3'd0,
      OP_LOAD      = 3'd1,
      OP_MULTIPLY  = 3'd2,
      OP_CONJUGATE = 3'd3,
      OP_MATRIX    = 3'd4
   } op_type;

   // rotation matrix is sent as four rows
   localparam int MATRIX_ROWS = 4;
   localparam int ROW_BITS    = 2;

endpackage

>>> rtl/quaternion_rotation_unit_top.sv
// quaternion rotation unit
// holds one orientation quaternion (x, y, z, w) in signed fixed point,
// WORD_BITS wide with FRAC_BITS fraction bits (q2.14 by default)
// request channel (req_*): one transfer carries an operation code and an
// operand quaternion: identity, load, multiply on the right (hamilton
// product), conjugate, or emit the 4x4 rotation matrix
// response channel (rsp_*): identity, load, multiply, conjugate and the
// unused codes return the new quaternion as one transfer with tlast set;
// the matrix operation returns four rows, tlast set on the fourth
// every multiply and matrix result cell is rounded half up once and saturated to the word range
// a result is registered: it is in the response register in the cycle
// after the request transfer
// throughput: one request per cycle unless stalled; a matrix request holds
// req_tready low until rows one to three have left the row counter
// the quaternion update is a single pass of 16 multipliers and adders, so
// back to back multiplies see the previous result at once
// reset: quaternion goes to identity, response register empties, row
// counter clears
// stall: while rsp_tready is low a waiting response holds and req_tready
// drops; a request is taken in the same cycle as the waiting response leaves
module quaternion_rotation_unit_top #(
   parameter int WORD_BITS = qru_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // operation, in_x, in_y, in_z, in_w (low to high), zero padded to bytes
   input  logic [((qru_pkg::OP_BITS+4*WORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_0, out_1, out_2, out_3 (low to high), zero padded to bytes
   output logic [((4*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // last
   output logic rsp_tlast
);
   import qru_pkg::*;

   localparam int W     = WORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int ACC_W = 2*W + 3;
   localparam int RSP_W = ((4*W+7)/8)*8;

   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] MAX_ACC = ACC_W'(WMAX);
   localparam logic signed [ACC_W-1:0] MIN_ACC = ACC_W'(WMIN);
   // one in word format, saturated when the format cannot hold it
   localparam logic signed [W-1:0] ONE_Q =
      (F >= W-1) ? WMAX : W'(longint'(1) << F);
   // rounding bias and the constant one at product scale
   localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(longint'(1) << (F-1));
   localparam logic signed [ACC_W-1:0] ONE_SQ = ACC_W'(longint'(1) << (2*F));
   localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(MATRIX_ROWS-1);

   // product scale to word: round half up, then saturate
   function automatic logic signed [W-1:0] round_sat(input logic signed [ACC_W-1:0] s);
      logic signed [ACC_W-1:0] t;
      t = (s + HALF) >>> F;
      if (t > MAX_ACC)
         round_sat = WMAX;
      else if (t < MIN_ACC)
         round_sat = WMIN;
      else
         round_sat = t[W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] mul(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p;
      p   = a * b;
      mul = ACC_W'(p);
   endfunction

   function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] a);
      neg_sat = (a == WMIN) ? WMAX : -a;
   endfunction

   // stored quaternion
   logic signed [W-1:0] cx_ff, cy_ff, cz_ff, cw_ff;
   logic signed [W-1:0] cx_in, cy_in, cz_in, cw_in;

   // response register and matrix row counter
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0][W-1:0]      rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;

   // request fields
   op_type              req_op;
   logic signed [W-1:0] qx, qy, qz, qw;

   logic out_free;
   logic busy;
   logic req_fire;

   // hamilton product sums
   logic signed [ACC_W-1:0] sx, sy, sz, sw;
   // matrix products and cells
   logic signed [ACC_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
   logic signed [W-1:0]     m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic [ROW_BITS-1:0]     row_sel;
   logic [3:0][W-1:0]       row_data;

   assign req_op = op_type'(req_tdata[OP_BITS-1:0]);
   assign qx     = req_tdata[OP_BITS       +: W];
   assign qy     = req_tdata[OP_BITS + W   +: W];
   assign qz     = req_tdata[OP_BITS + 2*W +: W];
   assign qw     = req_tdata[OP_BITS + 3*W +: W];

   // output register frees when empty or when its transfer completes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign busy       = (row_ff != '0);
   assign req_tready = out_free && !busy;
   assign req_fire   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

   // q' = q * operand
   assign sx = mul(cw_ff, qx) + mul(cx_ff, qw) + mul(cy_ff, qz) - mul(cz_ff, qy);
   assign sy = mul(cw_ff, qy) - mul(cx_ff, qz) + mul(cy_ff, qw) + mul(cz_ff, qx);
   assign sz = mul(cw_ff, qz) + mul(cx_ff, qy) - mul(cy_ff, qx) + mul(cz_ff, qw);
   assign sw = mul(cw_ff, qw) - mul(cx_ff, qx) - mul(cy_ff, qy) - mul(cz_ff, qz);

   assign pxx = mul(cx_ff, cx_ff);
   assign pyy = mul(cy_ff, cy_ff);
   assign pzz = mul(cz_ff, cz_ff);
   assign pxy = mul(cx_ff, cy_ff);
   assign pxz = mul(cx_ff, cz_ff);
   assign pyz = mul(cy_ff, cz_ff);
   assign pwx = mul(cw_ff, cx_ff);
   assign pwy = mul(cw_ff, cy_ff);
   assign pwz = mul(cw_ff, cz_ff);

   assign m00 = round_sat(ONE_SQ - (pyy <<< 1) - (pzz <<< 1));
   assign m01 = round_sat((pxy <<< 1) - (pwz <<< 1));
   assign m02 = round_sat((pxz <<< 1) + (pwy <<< 1));
   assign m10 = round_sat((pxy <<< 1) + (pwz <<< 1));
   assign m11 = round_sat(ONE_SQ - (pxx <<< 1) - (pzz <<< 1));
   assign m12 = round_sat((pyz <<< 1) - (pwx <<< 1));
   assign m20 = round_sat((pxz <<< 1) - (pwy <<< 1));
   assign m21 = round_sat((pyz <<< 1) + (pwx <<< 1));
   assign m22 = round_sat(ONE_SQ - (pxx <<< 1) - (pyy <<< 1));

   // row zero goes out with the request, later rows follow the counter
   assign row_sel = busy ? row_ff : '0;

   always_comb begin
      case (row_sel)
         2'd0:    row_data = {W'(0), m02, m01, m00};
         2'd1:    row_data = {W'(0), m12, m11, m10};
         2'd2:    row_data = {W'(0), m22, m21, m20};
         default: row_data = {ONE_Q, W'(0), W'(0), W'(0)};
      endcase
   end

   always_comb begin
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      cw_in        = cw_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      if (busy) begin
         // remaining matrix rows, one per free output slot
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = row_data;
            rsp_last_in  = (row_ff == LAST_ROW);
            row_in       = row_ff + ROW_BITS'(1);
         end
      end else if (req_fire) begin
         unique case (req_op)
            OP_IDENTITY: begin
               cx_in = '0;
               cy_in = '0;
               cz_in = '0;
               cw_in = ONE_Q;
            end
            OP_LOAD: begin
               cx_in = qx;
               cy_in = qy;
               cz_in = qz;
               cw_in = qw;
            end
            OP_MULTIPLY: begin
               cx_in = round_sat(sx);
               cy_in = round_sat(sy);
               cz_in = round_sat(sz);
               cw_in = round_sat(sw);
            end
            OP_CONJUGATE: begin
               cx_in = neg_sat(cx_ff);
               cy_in = neg_sat(cy_ff);
               cz_in = neg_sat(cz_ff);
            end
            default: begin
               // matrix and unused codes keep the quaternion
            end
         endcase
         rsp_valid_in = 1'b1;
         if (req_op == OP_MATRIX) begin
            rsp_data_in = row_data;
            rsp_last_in = 1'b0;
            row_in      = ROW_BITS'(1);
         end else begin
            rsp_data_in = {cw_in, cz_in, cy_in, cx_in};
            rsp_last_in = 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff        <= '0;
         cy_ff        <= '0;
         cz_ff        <= '0;
         cw_ff        <= ONE_Q;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         cz_ff        <= cz_in;
         cw_ff        <= cw_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, qualified by rsp_valid_ff
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

>>> rtl/qru_checker.sv
module qru_checker #(
   parameter int WORD_BITS = qru_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = qru_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [((qru_pkg::OP_BITS+4*WORD_BITS+7)/8)*8-1:0] req_tdata,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((4*WORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic rsp_tlast
);
   import qru_pkg::*;

   localparam int W = WORD_BITS;

   logic identity_fire;
   assign identity_fire = req_tvalid && req_tready &&
                          (req_tdata[OP_BITS-1:0] == OP_IDENTITY);

   // response register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // no new request while matrix rows are still pending
   a_rows_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken during matrix rows");

   // matrix rows follow without a gap
   a_rows_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap between matrix rows");

   // identity answers with zero vector part in a single transfer
   a_identity: assert property (@(posedge clock) disable iff (reset)
      identity_fire |=> rsp_tvalid && rsp_tlast && (rsp_tdata[3*W-1:0] == '0))
      else $error("identity result wrong");

endmodule

bind quaternion_rotation_unit_top qru_checker #(
   .WORD_BITS(WORD_BITS),
   .FRAC_BITS(FRAC_BITS)
) u_qru_checker (.*);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import qru_pkg::*;

   localparam int W        = WORD_BITS_DEF;
   localparam int F        = FRAC_BITS_DEF;
   localparam int REQ_BITS = ((OP_BITS + 4*W + 7) / 8) * 8;
   localparam int RSP_BITS = ((4*W + 7) / 8) * 8;

   // codes past the last defined operation: the block just echoes the quaternion
   localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd5;
   localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;

   localparam logic [W-1:0] Q_ONE = W'(1 << F);
   localparam logic [W-1:0] Q_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] Q_MIN = {1'b1, {(W-1){1'b0}}};

   // cycles without any transfer before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;
   localparam int RANDOM_ITEMS = 87;

   // one response transfer, out_0 in the low bits as on rsp_tdata
   typedef struct packed {
      logic         last;
      logic [W-1:0] c3;
      logic [W-1:0] c2;
      logic [W-1:0] c1;
      logic [W-1:0] c0;
   } row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tlast;

   // orientation as the block should hold it
   logic [W-1:0] att_x, att_y, att_z, att_w;
   row_type      expected_rows[$];

   int send_idle_pct;
   int recv_idle_pct;
   int errors;
   int idle_cycles;

   quaternion_rotation_unit_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [W-1:0] clamp(input longint v);
      longint top = (longint'(1) << (W-1)) - 1;
      longint bot = -(longint'(1) << (W-1));
      if (v > top) return top[W-1:0];
      if (v < bot) return bot[W-1:0];
      return v[W-1:0];
   endfunction

   // exact sum of products scaled by 2^F, rounded half up once, plus an offset
   function automatic logic [W-1:0] round_cell(input longint sum, input longint offset);
      return clamp(((sum + (longint'(1) << (F-1))) >>> F) + offset);
   endfunction

   task automatic push_row(input logic [W-1:0] c0, c1, c2, c3, input logic last);
      row_type r;
      r.c0 = c0;
      r.c1 = c1;
      r.c2 = c2;
      r.c3 = c3;
      r.last = last;
      expected_rows.push_back(r);
   endtask

   // update the held orientation and queue what the block must return
   task automatic apply_quaternion_op(input logic [OP_BITS-1:0] op,
                                      input logic [W-1:0] qx, qy, qz, qw);
      longint x, y, z, w, bx, by, bz, bw, one;
      x   = $signed(att_x);
      y   = $signed(att_y);
      z   = $signed(att_z);
      w   = $signed(att_w);
      bx  = $signed(qx);
      by  = $signed(qy);
      bz  = $signed(qz);
      bw  = $signed(qw);
      one = longint'(1) << F;
      case (op)
         OP_IDENTITY: begin
            att_x = '0;
            att_y = '0;
            att_z = '0;
            att_w = clamp(one);
         end
         OP_LOAD: begin
            att_x = qx;
            att_y = qy;
            att_z = qz;
            att_w = qw;
         end
         OP_MULTIPLY: begin
            // hamilton product, stored quaternion on the left
            att_x = round_cell(w*bx + x*bw + y*bz - z*by, 0);
            att_y = round_cell(w*by - x*bz + y*bw + z*bx, 0);
            att_z = round_cell(w*bz + x*by - y*bx + z*bw, 0);
            att_w = round_cell(w*bw - x*bx - y*by - z*bz, 0);
         end
         OP_CONJUGATE: begin
            // negating the most negative value saturates
            att_x = clamp(-x);
            att_y = clamp(-y);
            att_z = clamp(-z);
         end
         OP_MATRIX: begin
            push_row(round_cell(-2*y*y - 2*z*z, one), round_cell(2*x*y - 2*w*z, 0),
                     round_cell(2*x*z + 2*w*y, 0), '0, 1'b0);
            push_row(round_cell(2*x*y + 2*w*z, 0), round_cell(-2*x*x - 2*z*z, one),
                     round_cell(2*y*z - 2*w*x, 0), '0, 1'b0);
            push_row(round_cell(2*x*z - 2*w*y, 0), round_cell(2*y*z + 2*w*x, 0),
                     round_cell(-2*x*x - 2*y*y, one), '0, 1'b0);
            push_row('0, '0, '0, clamp(one), 1'b1);
         end
         default: ;
      endcase
      if (op != OP_MATRIX)
         push_row(att_x, att_y, att_z, att_w, 1'b1);
   endtask

   // ---------------------------------------------------------------- request side

   // one request transfer; valid stays high afterwards so back to back items
   // need no second assignment in the same step
   task automatic send_quaternion_op(input logic [OP_BITS-1:0] op,
                                     input logic [W-1:0] qx, qy, qz, qw);
      logic [REQ_BITS-1:0] word;
      word = '0;
      word[OP_BITS+4*W-1:0] = {qw, qz, qy, qx, op};
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_quaternion_op(op, qx, qy, qz, qw);
   endtask

   // hold off requests until every queued response has been seen
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_rows.size() != 0);
   endtask

   // ---------------------------------------------------------------- response side

   // receiver backpressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      row_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tlast, rsp_tdata[4*W-1:0]};
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got %h", $time, got);
            errors++;
         end else begin
            want = expected_rows.pop_front();
            for (int i = 0; i < 4; i++)
               if (got[i*W +: W] !== want[i*W +: W]) begin
                  $display("%0t: out_%0d expected %0d got %0d", $time, i,
                           $signed(want[i*W +: W]), $signed(got[i*W +: W]));
                  errors++;
               end
            if (got.last !== want.last) begin
               $display("%0t: last expected %0b got %0b", $time, want.last, got.last);
               errors++;
            end
         end
      end
   end

   // hang detection: counts cycles in which neither channel moves a transfer
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   function automatic logic [W-1:0] pick_component();
      case ($urandom_range(3))
         0: return W'($urandom);
         1: return W'($urandom_range(2*(1 << F))) - Q_ONE;
         2: return W'($urandom_range(1 << F)) - W'(1 << (F-1));
         default: begin
            case ($urandom_range(5))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return '0;
               3: return Q_ONE;
               4: return -Q_ONE;
               default: return W'(1);
            endcase
         end
      endcase
   endfunction

   // orientation after reset must be identity
   task automatic test_after_reset();
      send_quaternion_op(OP_UNUSED_LO, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      send_quaternion_op(OP_MATRIX, '0, '0, '0, '0);
   endtask

   // full scale operands, saturation of products, negation and matrix cells
   task automatic test_field_extremes();
      send_quaternion_op(OP_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_quaternion_op(OP_MATRIX, '0, '0, '0, '0);
      send_quaternion_op(OP_MULTIPLY, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_quaternion_op(OP_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_quaternion_op(OP_MULTIPLY, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      send_quaternion_op(OP_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_quaternion_op(OP_CONJUGATE, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_quaternion_op(OP_LOAD, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      send_quaternion_op(OP_MATRIX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_quaternion_op(OP_IDENTITY, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
   endtask

   // exact half lsb results, rounded toward plus infinity either sign
   task automatic test_rounding_ties();
      send_quaternion_op(OP_LOAD, '0, '0, '0, W'(1));
      send_quaternion_op(OP_MULTIPLY, '0, '0, '0, W'(1 << (F-1)));
      send_quaternion_op(OP_LOAD, '0, '0, '0, -W'(1));
      send_quaternion_op(OP_MULTIPLY, '0, '0, '0, W'(1 << (F-1)));
      send_quaternion_op(OP_LOAD, W'(1), '0, '0, '0);
      send_quaternion_op(OP_MULTIPLY, W'(1 << (F-1)), W'(1 << (F-1)), '0, '0);
   endtask

   // codes past the matrix operation change nothing
   task automatic test_unused_codes();
      send_quaternion_op(OP_LOAD, pick_component(), pick_component(),
                         pick_component(), pick_component());
      for (int c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
         send_quaternion_op(OP_BITS'(c), W'($urandom), W'($urandom),
                            W'($urandom), W'($urandom));
   endtask

   // random chains: loads of random quaternions, runs of products,
   // matrix readouts, with the odd conjugate, identity and unused code
   task automatic test_random_ops(input int count);
      logic [OP_BITS-1:0] op;
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 15)      op = OP_LOAD;
         else if (r < 55) op = OP_MULTIPLY;
         else if (r < 72) op = OP_MATRIX;
         else if (r < 82) op = OP_CONJUGATE;
         else if (r < 90) op = OP_IDENTITY;
         else             op = OP_UNUSED_LO + OP_BITS'($urandom_range(2));
         send_quaternion_op(op, pick_component(), pick_component(),
                            pick_component(), pick_component());
         // drain once mid phase so the block runs dry and restarts
         if (n == count / 2)
            wait_for_results();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      errors        = 0;
      att_x         = '0;
      att_y         = '0;
      att_z         = '0;
      att_w         = Q_ONE;
      // sender gaps light, receiver stalls heavy
      send_idle_pct = 37;
      recv_idle_pct = 88;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_field_extremes();
      test_rounding_ties();
      test_unused_codes();
      test_random_ops(RANDOM_ITEMS);

      // sender gaps heavy, receiver stalls light
      send_idle_pct = 88;
      recv_idle_pct = 37;
      test_random_ops(RANDOM_ITEMS);

      // both sides at full rate
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_ops(RANDOM_ITEMS);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/qru_pkg.sv
rtl/quaternion_rotation_unit_top.sv
rtl/qru_checker.sv
sim/testbench.sv
